@@ hdl/utlm_pkg.sv @@
// Package with the types and constants of the ultrasonic tank level meter.
`default_nettype none

package utlm_pkg;

	// Default store depth of the frame buffer.
	localparam int FRAME_DEPTH_DEF = 10;

	// Field widths.
	localparam int BYTE_W = 8;
	localparam int DIST_W = 16;
	localparam int PCT_W  = 8;

	// Divider sizes: the quotient never exceeds 100, so seven bits suffice.
	localparam int QUOT_W = 7;
	localparam int NUM_W  = DIST_W + QUOT_W;

	// Sensor link characters and limits.
	localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_R     = 8'h52;
	localparam logic [BYTE_W-1:0] BYTE_UNSET = 8'hFF;
	localparam logic [DIST_W-1:0] DIGIT_ZERO = 16'h0030;
	localparam logic [DIST_W-1:0] SENSOR_TOP = 16'h1380;
	localparam logic [PCT_W-1:0]  PCT_FULL   = 8'd100;
	localparam logic [PCT_W-1:0]  PCT_LOW    = 8'd1;
	localparam logic [NUM_W-1:0]  PCT_SCALE  = 23'd100;

	// Frame layout: tag byte, four digits, terminator.
	localparam int TAG_POS   = 0;
	localparam int DIGIT_POS = 1;
	localparam int TERM_POS  = 5;
	localparam int DIGIT_CNT = 4;

	// Reset values of the configuration registers.
	localparam logic [DIST_W-1:0] EMPTY_RST = 16'hFFFF;
	localparam logic [DIST_W-1:0] FULL_RST  = 16'd300;

	// Configuration register indexes.
	typedef enum logic {
		CFG_EMPTY = 1'b0,
		CFG_FULL  = 1'b1
	} cfg_idx_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SUM,
		ST_PCT,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ hdl/ultrasonic_tank_level_meter.sv @@
// Top level of the ultrasonic tank level meter: frame capture, digit sum and fill divider.
//
// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_stall     rx_byte
// out       source     out_valid / out_stall   frame_ok, distance_mm, fill_percent
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A byte other than carriage return is stored and gives no result.
// A carriage return starts the check step; a rejected frame then goes straight to the result,
// a valid one first passes four Horner steps of the digit accumulator and a range step,
// and one that needs a division also seven steps of the restoring divider; the result is
// then held until transferred.
// in_stall stays high from a carriage return until its result has been transferred.
// Reset clears the frame store, the index, the last reading and loads the register defaults.
`default_nettype none

module ultrasonic_tank_level_meter #(
	parameter int FRAME_DEPTH = utlm_pkg::FRAME_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [utlm_pkg::BYTE_W-1:0]  rx_byte,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              frame_ok,
	output logic      [utlm_pkg::DIST_W-1:0]  distance_mm,
	output logic      [utlm_pkg::PCT_W-1:0]   fill_percent,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_index,
	input  wire logic [utlm_pkg::DIST_W-1:0]  cfg_data
);

	localparam int IDX_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_DEPTH - 1);

	utlm_pkg::state_t state_q, state_d;

	logic [utlm_pkg::BYTE_W-1:0] store_q [FRAME_DEPTH];
	logic [IDX_W-1:0]            wr_idx_q;
	logic [utlm_pkg::DIST_W-1:0] empty_q, full_q;
	logic [utlm_pkg::DIST_W-1:0] dist_q, acc_q;
	logic [utlm_pkg::PCT_W-1:0]  pct_q;
	logic                        ok_q;
	logic [2:0]                  step_q;
	logic [utlm_pkg::NUM_W-1:0]  num_q, ds_q;
	logic [utlm_pkg::QUOT_W-1:0] quot_q;

	logic                        in_xfer, out_xfer, is_cr;
	logic                        frame_valid, cfg_unset, in_span, beyond_empty, near_full;
	logic [IDX_W-1:0]            digit_sel;
	logic [utlm_pkg::DIST_W-1:0] digit_val, acc_next;
	logic                        div_take;

	// Configuration is always accepted.
	assign cfg_ready = 1'b1;

	// Handshake events.
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign is_cr    = (rx_byte == utlm_pkg::BYTE_CR);

	// Frame check and range decisions for the fill calculation.
	always_comb begin
		frame_valid  = (store_q[utlm_pkg::TAG_POS] == utlm_pkg::BYTE_R) &&
		               (store_q[utlm_pkg::TERM_POS] == utlm_pkg::BYTE_CR);
		cfg_unset    = (empty_q[15:8] == utlm_pkg::BYTE_UNSET) ||
		               (empty_q[7:0] == utlm_pkg::BYTE_UNSET);
		in_span      = (dist_q >= full_q) && (dist_q < empty_q);
		beyond_empty = (dist_q > empty_q);
		near_full    = (dist_q < full_q);
	end

	// Horner step of the digit accumulator: acc * 10 + digit, modulo 2^16.
	always_comb begin
		digit_sel = IDX_W'(utlm_pkg::DIGIT_POS) + IDX_W'(step_q[1:0]);
		digit_val = {{(utlm_pkg::DIST_W - utlm_pkg::BYTE_W){1'b0}}, store_q[digit_sel]}
		            - utlm_pkg::DIGIT_ZERO;
		acc_next  = (acc_q << 3) + (acc_q << 1) + digit_val;
	end

	// Restoring divider compare.
	assign div_take = (num_q >= ds_q);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			utlm_pkg::ST_IDLE: begin
				if (in_xfer && is_cr) state_d = utlm_pkg::ST_CHECK;
			end
			utlm_pkg::ST_CHECK: begin
				state_d = frame_valid ? utlm_pkg::ST_SUM : utlm_pkg::ST_DONE;
			end
			utlm_pkg::ST_SUM: begin
				if (step_q == 3'(utlm_pkg::DIGIT_CNT - 1)) state_d = utlm_pkg::ST_PCT;
			end
			utlm_pkg::ST_PCT: begin
				state_d = (!cfg_unset && in_span) ? utlm_pkg::ST_DIV : utlm_pkg::ST_DONE;
			end
			utlm_pkg::ST_DIV: begin
				if (step_q == 3'd0) state_d = utlm_pkg::ST_DONE;
			end
			utlm_pkg::ST_DONE: begin
				if (!out_stall) state_d = utlm_pkg::ST_IDLE;
			end
			default: state_d = utlm_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs of the sequencer.
	always_comb begin
		in_stall  = (state_q != utlm_pkg::ST_IDLE);
		out_valid = (state_q == utlm_pkg::ST_DONE);
	end

	// Result payload comes straight from the held registers.
	assign frame_ok     = ok_q;
	assign distance_mm  = dist_q;
	assign fill_percent = pct_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= utlm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= utlm_pkg::EMPTY_RST;
			full_q  <= utlm_pkg::FULL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (utlm_pkg::cfg_idx_t'(cfg_index))
				utlm_pkg::CFG_EMPTY: empty_q <= cfg_data;
				utlm_pkg::CFG_FULL:  full_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame store and its wrapping write index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_DEPTH; i++) store_q[i] <= '0;
			wr_idx_q <= '0;
		end else if (in_xfer) begin
			store_q[wr_idx_q] <= rx_byte;
			if (is_cr || wr_idx_q == IDX_LAST) begin
				wr_idx_q <= '0;
			end else begin
				wr_idx_q <= wr_idx_q + IDX_W'(1);
			end
		end
	end

	// Last reading, kept across rejected frames, and frame status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			pct_q  <= '0;
			ok_q   <= 1'b0;
		end else begin
			unique case (state_q)
				utlm_pkg::ST_CHECK: ok_q <= frame_valid;
				utlm_pkg::ST_SUM: begin
					if (step_q == 3'(utlm_pkg::DIGIT_CNT - 1)) dist_q <= acc_next;
				end
				utlm_pkg::ST_PCT: begin
					if (!cfg_unset && !in_span) begin
						if (beyond_empty) begin
							pct_q <= (dist_q > utlm_pkg::SENSOR_TOP) ? utlm_pkg::PCT_FULL
							                                          : utlm_pkg::PCT_LOW;
						end else if (near_full) begin
							pct_q <= utlm_pkg::PCT_FULL;
						end
					end
				end
				utlm_pkg::ST_DIV: begin
					if (step_q == 3'd0) pct_q <= {1'b0, quot_q[utlm_pkg::QUOT_W-2:0], div_take};
				end
				default: ;
			endcase
		end
	end

	// Working registers of the accumulator and the divider.
	always_ff @(posedge clk) begin
		unique case (state_q)
			utlm_pkg::ST_CHECK: begin
				acc_q  <= '0;
				step_q <= '0;
			end
			utlm_pkg::ST_SUM: begin
				acc_q  <= acc_next;
				step_q <= step_q + 3'd1;
			end
			utlm_pkg::ST_PCT: begin
				// Numerator (empty - d) * 100, divisor (empty - full) aligned to the top quotient bit.
				num_q  <= utlm_pkg::NUM_W'(empty_q - dist_q) * utlm_pkg::PCT_SCALE;
				ds_q   <= utlm_pkg::NUM_W'(empty_q - full_q) << (utlm_pkg::QUOT_W - 1);
				quot_q <= '0;
				step_q <= 3'(utlm_pkg::QUOT_W - 1);
			end
			utlm_pkg::ST_DIV: begin
				if (div_take) num_q <= num_q - ds_q;
				ds_q   <= ds_q >> 1;
				quot_q <= {quot_q[utlm_pkg::QUOT_W-2:0], div_take};
				step_q <= step_q - 3'd1;
			end
			default: ;
		endcase
	end

	// The block never takes a byte while a result is on offer.
	a_no_accept_while_offer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("byte accepted while a result is pending");

	// A carriage return always restarts the frame at entry zero.
	a_cr_resets_index: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && is_cr) |=> (wr_idx_q == '0))
		else $error("write index not cleared after carriage return");

	// The write index stays inside the store.
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= IDX_LAST)
		else $error("write index beyond the frame store");

	// The partial remainder stays below twice the shifted divisor.
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == utlm_pkg::ST_DIV) |-> ({1'b0, num_q} < {ds_q, 1'b0}))
		else $error("divider remainder out of bound");

	// A rejected frame leaves the reading untouched.
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == utlm_pkg::ST_CHECK && !frame_valid) |=> $stable(dist_q) && $stable(pct_q))
		else $error("rejected frame changed the reading");

endmodule

`default_nettype wire
